// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, disabled while reset is low
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// implication form of the above
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- hdl/lpbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpbc_pkg
// Types and constants of the leaky PID balance controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbc_pkg;

  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned ACC_W     = 60;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BIT_CNT_W = 4;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = 4'd15;

  // 0.95 as a 16-bit fraction
  localparam logic [GAIN_W-1:0] LEAK_NUM = 16'd62259;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_SETPOINT = 3'd4;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 16'd3584;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST    = 16'd2048;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST    = 16'd53760;
  localparam logic [GAIN_W-1:0] LOOP_GAIN_RST     = 16'd545;
  localparam logic [GAIN_W-1:0] TILT_SETPOINT_RST = 16'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAK,
    ST_SUM,
    ST_PTERM,
    ST_ITERM,
    ST_DTERM,
    ST_SCALE,
    ST_LOOP,
    ST_CLAMP
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/leaky_pid_balance_controller.sv -----
// A sample passes the leak, sum, P, I and D term, scale, loop and clamp steps
// before its result beat is valid; a new one is taken only in idle. A single
// shift-add multiplier retires one gain bit per cycle, shared by five 16-bit
// products. The result register frees the input side while a result waits.
// Reset (rst_ni low, asynchronous): gains and setpoint to defaults,
// leaky sum and previous error to zero, no result pending.
// ----------------------------------------------------------------------------
// leaky_pid_balance_controller
// PID balance controller with leaky integral, bit-serial shared multiplier
// and symmetric output clamp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module leaky_pid_balance_controller (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [lpbc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [lpbc_pkg::GAIN_W-1:0]          cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [15:0]                   tilt_angle_i,
  input  wire logic [15:0]                          speed_cap_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [16:0]                        drive_speed_o,
  output logic signed [16:0]                        tilt_error_o,
  output logic                                      hit_cap_o
);

  localparam int unsigned ACC_W  = lpbc_pkg::ACC_W;
  localparam int unsigned ERR_W  = lpbc_pkg::ERR_W;
  localparam int unsigned SUM_W  = lpbc_pkg::SUM_W;
  localparam int unsigned DIFF_W = lpbc_pkg::DIFF_W;
  localparam int unsigned GAIN_W = lpbc_pkg::GAIN_W;

  lpbc_pkg::state_e state_q, state_d;

  logic [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, loop_gain_q;
  logic signed [15:0] tilt_setpoint_q;

  logic signed [SUM_W-1:0]  leaky_sum_q, leaky_sum_d;
  logic signed [ERR_W-1:0]  prev_err_q, prev_err_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic [15:0]              cap_q, cap_d;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic [GAIN_W-1:0]       mplr_q, mplr_d;
  logic [lpbc_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [16:0]      drive_q, drive_d;
  logic signed [ERR_W-1:0] out_err_q, out_err_d;
  logic                    hit_q, hit_d;

  logic in_accept, out_free, mult_active, last_bit;
  logic signed [ACC_W-1:0] acc_step;
  logic signed [SUM_W:0]   sum_raw;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [43:0]      drive_full, cap_pos, cap_neg;
  logic                    clamp_lo, clamp_hi;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_bit    = (bit_cnt_q == lpbc_pkg::BIT_LAST);

  // one multiplier bit per cycle
  assign acc_step = mplr_q[0] ? (acc_q + mcand_q) : acc_q;

  // leak term is floor(sum * 0.95), sits in product bits [39:16]
  assign sum_raw = {acc_q[39], acc_q[39:16]} + {{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
  always_comb begin
    if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
      sum_sat = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
  end

  assign drive_full = acc_q[ACC_W-1:16];
  assign cap_pos    = {28'd0, cap_q};
  assign cap_neg    = -cap_pos;
  assign clamp_lo   = (drive_full <= cap_neg);
  assign clamp_hi   = (drive_full >= cap_pos);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpbc_pkg::ST_IDLE:  if (in_accept) state_d = lpbc_pkg::ST_LEAK;
      lpbc_pkg::ST_LEAK:  if (last_bit) state_d = lpbc_pkg::ST_SUM;
      lpbc_pkg::ST_SUM:   state_d = lpbc_pkg::ST_PTERM;
      lpbc_pkg::ST_PTERM: if (last_bit) state_d = lpbc_pkg::ST_ITERM;
      lpbc_pkg::ST_ITERM: if (last_bit) state_d = lpbc_pkg::ST_DTERM;
      lpbc_pkg::ST_DTERM: if (last_bit) state_d = lpbc_pkg::ST_SCALE;
      lpbc_pkg::ST_SCALE: state_d = lpbc_pkg::ST_LOOP;
      lpbc_pkg::ST_LOOP:  if (last_bit) state_d = lpbc_pkg::ST_CLAMP;
      lpbc_pkg::ST_CLAMP: if (out_free) state_d = lpbc_pkg::ST_IDLE;
      default:            state_d = lpbc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o  = (state_q != lpbc_pkg::ST_IDLE);
    mult_active = 1'b0;
    leaky_sum_d = leaky_sum_q;
    prev_err_d  = prev_err_q;
    err_d       = err_q;
    diff_d      = diff_q;
    cap_d       = cap_q;
    acc_d       = acc_q;
    mcand_d     = {mcand_q[ACC_W-2:0], 1'b0};
    mplr_d      = {1'b0, mplr_q[GAIN_W-1:1]};
    out_valid_d = out_valid_q && out_stall_i;
    drive_d     = drive_q;
    out_err_d   = out_err_q;
    hit_d       = hit_q;
    case (state_q)
      lpbc_pkg::ST_IDLE: begin
        mcand_d = mcand_q;
        mplr_d  = mplr_q;
        if (in_accept) begin
          err_d   = {tilt_angle_i[15], tilt_angle_i} - {tilt_setpoint_q[15], tilt_setpoint_q};
          cap_d   = speed_cap_i;
          acc_d   = '0;
          mcand_d = {{(ACC_W-SUM_W){leaky_sum_q[SUM_W-1]}}, leaky_sum_q};
          mplr_d  = lpbc_pkg::LEAK_NUM;
        end
      end
      lpbc_pkg::ST_LEAK: begin
        mult_active = 1'b1;
        acc_d       = acc_step;
      end
      lpbc_pkg::ST_SUM: begin
        leaky_sum_d = sum_sat;
        prev_err_d  = err_q;
        diff_d      = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
        acc_d       = '0;
        mcand_d     = {{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mplr_d      = prop_gain_q;
      end
      lpbc_pkg::ST_PTERM: begin
        mult_active = 1'b1;
        acc_d       = acc_step;
        if (last_bit) begin
          mcand_d = {{(ACC_W-SUM_W){leaky_sum_q[SUM_W-1]}}, leaky_sum_q};
          mplr_d  = integ_gain_q;
        end
      end
      lpbc_pkg::ST_ITERM: begin
        mult_active = 1'b1;
        acc_d       = acc_step;
        if (last_bit) begin
          mcand_d = {{(ACC_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
          mplr_d  = deriv_gain_q;
        end
      end
      lpbc_pkg::ST_DTERM: begin
        mult_active = 1'b1;
        acc_d       = acc_step;
      end
      lpbc_pkg::ST_SCALE: begin
        acc_d   = '0;
        mcand_d = acc_q;
        mplr_d  = loop_gain_q;
      end
      lpbc_pkg::ST_LOOP: begin
        mult_active = 1'b1;
        acc_d       = acc_step;
      end
      lpbc_pkg::ST_CLAMP: begin
        mcand_d = mcand_q;
        mplr_d  = mplr_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_err_d   = err_q;
          hit_d       = clamp_lo || clamp_hi;
          if (clamp_lo) begin
            drive_d = cap_neg[16:0];
          end else if (clamp_hi) begin
            drive_d = {1'b0, cap_q};
          end else begin
            drive_d = drive_full[16:0];
          end
        end
      end
      default: begin
        mcand_d = mcand_q;
        mplr_d  = mplr_q;
      end
    endcase
    bit_cnt_d = mult_active ? (bit_cnt_q + 1'b1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= lpbc_pkg::ST_IDLE;
      bit_cnt_q       <= '0;
      out_valid_q     <= 1'b0;
      leaky_sum_q     <= '0;
      prev_err_q      <= '0;
      prop_gain_q     <= lpbc_pkg::PROP_GAIN_RST;
      integ_gain_q    <= lpbc_pkg::INTEG_GAIN_RST;
      deriv_gain_q    <= lpbc_pkg::DERIV_GAIN_RST;
      loop_gain_q     <= lpbc_pkg::LOOP_GAIN_RST;
      tilt_setpoint_q <= lpbc_pkg::TILT_SETPOINT_RST;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
      leaky_sum_q <= leaky_sum_d;
      prev_err_q  <= prev_err_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lpbc_pkg::REG_PROP_GAIN:     prop_gain_q     <= cfg_data_i;
          lpbc_pkg::REG_INTEG_GAIN:    integ_gain_q    <= cfg_data_i;
          lpbc_pkg::REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i;
          lpbc_pkg::REG_LOOP_GAIN:     loop_gain_q     <= cfg_data_i;
          lpbc_pkg::REG_TILT_SETPOINT: tilt_setpoint_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    diff_q    <= diff_d;
    cap_q     <= cap_d;
    acc_q     <= acc_d;
    mcand_q   <= mcand_d;
    mplr_q    <= mplr_d;
    drive_q   <= drive_d;
    out_err_q <= out_err_d;
    hit_q     <= hit_d;
  end

  assign out_valid_o   = out_valid_q;
  assign drive_speed_o = drive_q;
  assign tilt_error_o  = out_err_q;
  assign hit_cap_o     = hit_q;

  `ASSERT_IMPLIES(a_sum_upd_in_sum, clk_i, rst_ni, !$stable(leaky_sum_q),
    $past(state_q) == lpbc_pkg::ST_SUM, "leaky sum changed outside the sum step")
  `ASSERT_IMPLIES(a_result_from_clamp, clk_i, rst_ni, $rose(out_valid_o),
    $past(state_q) == lpbc_pkg::ST_CLAMP, "result beat not issued by the clamp step")
  `ASSERT_IMPLIES(a_cnt_idle_zero, clk_i, rst_ni,
    state_q == lpbc_pkg::ST_IDLE || state_q == lpbc_pkg::ST_CLAMP,
    bit_cnt_q == '0, "bit counter not aligned at product boundary")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// leaky PID balance controller testbench
// Drives tilt samples and speed caps with random gaps and output stalls,
// predicts each drive beat from its own copy of gains, leaky sum and last
// error, and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam longint      LEAK_FACTOR = 62259;
  localparam longint      SUM_HI      = 8388607;
  localparam longint      SUM_LO      = -8388608;

  localparam logic [lpbc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [lpbc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [16:0] drive;
    logic signed [16:0] err;
    logic               hit;
  } drive_beat_t;

  typedef enum int unsigned {SEQ_NOISE, SEQ_WALK, SEQ_PINNED, SEQ_NEAR} seq_kind_e;

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                cfg_valid_i  = 1'b0;
  logic                                cfg_ready_o;
  logic [lpbc_pkg::CFG_IDX_W-1:0]      cfg_index_i  = '0;
  logic [lpbc_pkg::GAIN_W-1:0]         cfg_data_i   = '0;
  logic                                in_valid_i   = 1'b0;
  logic                                in_stall_o;
  logic signed [15:0]                  tilt_angle_i = '0;
  logic [15:0]                         speed_cap_i  = '0;
  logic                                out_valid_o;
  logic                                out_stall_i  = 1'b0;
  logic signed [16:0]                  drive_speed_o;
  logic signed [16:0]                  tilt_error_o;
  logic                                hit_cap_o;

  // predictor copy of registers and state
  logic [15:0]        kp       = lpbc_pkg::PROP_GAIN_RST;
  logic [15:0]        ki       = lpbc_pkg::INTEG_GAIN_RST;
  logic [15:0]        kd       = lpbc_pkg::DERIV_GAIN_RST;
  logic [15:0]        kloop    = lpbc_pkg::LOOP_GAIN_RST;
  logic signed [15:0] setpoint = lpbc_pkg::TILT_SETPOINT_RST;
  logic signed [23:0] leak_sum = '0;
  logic signed [16:0] prev_err = '0;

  drive_beat_t pending_drive[$];
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_eager      = 1'b0;
  bit          rx_eager      = 1'b0;

  leaky_pid_balance_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tilt_angle_i  (tilt_angle_i),
    .speed_cap_i   (speed_cap_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_speed_o (drive_speed_o),
    .tilt_error_o  (tilt_error_o),
    .hit_cap_o     (hit_cap_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic drive_beat_t predict_drive(input logic signed [15:0] tilt,
                                                input logic [15:0] cap);
    longint      e;
    longint      s;
    longint      inner;
    longint      d;
    longint      c;
    drive_beat_t r;
    e = longint'(tilt) - longint'(setpoint);
    s = ((longint'(leak_sum) * LEAK_FACTOR) >>> 16) + e;
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    leak_sum = s[23:0];
    inner = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - longint'(prev_err));
    prev_err = e[16:0];
    d = (inner * longint'(kloop)) >>> 16;
    c = longint'(cap);
    r.hit = 1'b0;
    if (d <= -c) begin
      d = -c;
      r.hit = 1'b1;
    end else if (d >= c) begin
      d = c;
      r.hit = 1'b1;
    end
    r.drive = d[16:0];
    r.err   = e[16:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_cap();
    case ($urandom_range(0, 3))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_sample(input logic signed [15:0] tilt, input logic [15:0] cap);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    tilt_angle_i <= tilt;
    speed_cap_i  <= cap;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_drive.push_back(predict_drive(tilt, cap));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lpbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      lpbc_pkg::REG_PROP_GAIN:     kp       = val;
      lpbc_pkg::REG_INTEG_GAIN:    ki       = val;
      lpbc_pkg::REG_DERIV_GAIN:    kd       = val;
      lpbc_pkg::REG_LOOP_GAIN:     kloop    = val;
      lpbc_pkg::REG_TILT_SETPOINT: setpoint = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_gains(input logic [15:0] p, input logic [15:0] i,
                               input logic [15:0] d, input logic [15:0] k,
                               input logic [15:0] sp);
    wait_drained();
    write_reg(lpbc_pkg::REG_PROP_GAIN, p);
    write_reg(lpbc_pkg::REG_INTEG_GAIN, i);
    write_reg(lpbc_pkg::REG_DERIV_GAIN, d);
    write_reg(lpbc_pkg::REG_LOOP_GAIN, k);
    write_reg(lpbc_pkg::REG_TILT_SETPOINT, sp);
  endtask

  task automatic test_reset_defaults();
    push_sample(16'sd0, 16'hFFFF);
    push_sample(16'sh7FFF, 16'hFFFF);
    push_sample(-16'sd32768, 16'hFFFF);
    push_sample(16'sd100, 16'h0000);
  endtask

  // unit gains make drive equal the error, so caps can sit exactly on it
  task automatic test_clamp_edges();
    program_gains(16'd256, 16'd0, 16'd0, 16'd256, 16'd0);
    push_sample(16'sd1000, 16'd1000);
    push_sample(16'sd1000, 16'd1001);
    push_sample(-16'sd1000, 16'd1000);
    push_sample(-16'sd1000, 16'd1001);
    push_sample(16'sd5, 16'd0);
    push_sample(-16'sd5, 16'd0);
    push_sample(16'sd0, 16'd0);
  endtask

  task automatic test_setpoint_extremes();
    wait_drained();
    write_reg(lpbc_pkg::REG_TILT_SETPOINT, 16'h8000);
    push_sample(16'sh7FFF, 16'hFFFF);
    push_sample(-16'sd32768, 16'hFFFF);
    wait_drained();
    write_reg(lpbc_pkg::REG_TILT_SETPOINT, 16'h7FFF);
    push_sample(-16'sd32768, 16'hFFFF);
    push_sample(16'sh7FFF, 16'hFFFF);
  endtask

  task automatic test_spare_index();
    wait_drained();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h5A5A);
    push_sample(16'sd300, 16'hFFFF);
    push_sample(-16'sd300, 16'hFFFF);
  endtask

  task automatic test_gain_extremes();
    program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    push_sample(16'sd1, 16'hFFFF);
    push_sample(-16'sd1, 16'hFFFF);
    program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    push_sample(16'sh7FFF, 16'hFFFF);
    push_sample(-16'sd32768, 16'd1);
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned        sent;
    int unsigned        run_len;
    seq_kind_e          kind;
    int                 walk;
    logic signed [15:0] pinned;
    sent = 0;
    while (sent < n_items) begin
      run_len  = $urandom_range(1, 30);
      kind     = seq_kind_e'($urandom_range(0, 3));
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      walk     = int'($urandom_range(0, 65535)) - 32768;
      pinned   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      repeat (run_len) begin
        case (kind)
          SEQ_NOISE:  push_sample(16'($urandom()), pick_cap());
          SEQ_WALK: begin
            walk += int'($urandom_range(0, 64)) - 32;
            if (walk > 32767) walk = 32767;
            if (walk < -32768) walk = -32768;
            push_sample(16'(walk), pick_cap());
          end
          SEQ_PINNED: push_sample(pinned, pick_cap());
          default:    push_sample(setpoint + 16'(int'($urandom_range(0, 512)) - 256),
                                  pick_cap());
        endcase
      end
      sent += run_len;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  task automatic test_random();
    program_gains(lpbc_pkg::PROP_GAIN_RST, lpbc_pkg::INTEG_GAIN_RST,
                  lpbc_pkg::DERIV_GAIN_RST, lpbc_pkg::LOOP_GAIN_RST,
                  lpbc_pkg::TILT_SETPOINT_RST);
    run_random_phase(150);
    program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    run_random_phase(150);
    program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'($urandom()));
    run_random_phase(150);
    program_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 512)),
                  16'($urandom_range(0, 4096)), 16'($urandom_range(0, 512)),
                  16'($urandom_range(0, 4096)));
    run_random_phase(150);
    program_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()));
    run_random_phase(150);
    program_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'h8000);
    run_random_phase(150);
  endtask

  // receiver holds off long enough for the block to back up and stall its input
  task automatic test_output_hold();
    program_gains(lpbc_pkg::PROP_GAIN_RST, lpbc_pkg::INTEG_GAIN_RST,
                  lpbc_pkg::DERIV_GAIN_RST, lpbc_pkg::LOOP_GAIN_RST,
                  lpbc_pkg::TILT_SETPOINT_RST);
    rx_hold_cycles = 600;
    tx_eager = 1'b1;
    repeat (12) push_sample(16'($urandom()), pick_cap());
    tx_eager = 1'b0;
    wait_drained();
    repeat (6) push_sample(16'($urandom()), pick_cap());
  endtask

  initial begin : result_sink
    int unsigned pause;
    forever begin
      if (rx_hold_cycles != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles - 1) @(negedge clk_i);
        rx_hold_cycles = 0;
      end
      pause = rx_eager ? 0 : $urandom_range(0, 13);
      if (pause != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (pause - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o && rx_hold_cycles == 0) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    drive_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected result beat: drive_speed %0d tilt_error %0d hit_cap %0b",
               drive_speed_o, tilt_error_o, hit_cap_o);
        mismatches++;
      end else begin
        exp_beat = pending_drive.pop_front();
        if (drive_speed_o !== exp_beat.drive) begin
          $error("drive_speed: expected %0d, got %0d", exp_beat.drive, drive_speed_o);
          mismatches++;
        end
        if (tilt_error_o !== exp_beat.err) begin
          $error("tilt_error: expected %0d, got %0d", exp_beat.err, tilt_error_o);
          mismatches++;
        end
        if (hit_cap_o !== exp_beat.hit) begin
          $error("hit_cap: expected %0b, got %0b", exp_beat.hit, hit_cap_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_clamp_edges();
    test_setpoint_extremes();
    test_spare_index();
    test_gain_extremes();
    test_random();
    test_output_hold();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
